// ===== hw/rtl/pfga_pkg.sv =====
// Shared types, constants and helpers of the page frame grant allocator.
package pfga_pkg;

  localparam int MAX_PAGES = 65536;
  localparam int TBL_AW    = $clog2(MAX_PAGES);
  localparam int FRAME_W   = 20;
  localparam int FRAME_XW  = FRAME_W + 1;
  localparam int SP_FRAMES = 1024;
  localparam int SP_CW     = $clog2(SP_FRAMES);
  localparam int CFG_IW    = 2;

  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_SHARED   = 3'd1;
  localparam logic [2:0] ST_GONE     = 3'd2;
  localparam logic [2:0] ST_RESERVED = 3'd3;
  localparam logic [2:0] ST_ROOT     = 3'd4;

  localparam logic [CFG_IW-1:0] CFG_MEM_LOW  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MEM_HIGH = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_INFO     = 2'd2;

  localparam logic [FRAME_W-1:0] MEM_HIGH_RST = 20'd65536;

  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_MAP = 2'd2;

  localparam logic [31:0] W_ANY      = 32'hFFFF_FFFC;
  localparam logic [31:0] W_ANY_ALT  = 32'hFFFF_FFFE;
  localparam logic [31:0] W_INFO     = 32'h0000_0001;
  localparam logic [31:0] W_WIN_LO   = 32'h4000_0004;
  localparam logic [31:0] W_WIN_HI   = 32'hC000_0000;
  localparam logic [31:0] W_USER_TOP = 32'h4000_0000;
  localparam logic [31:0] DEV_OFFSET = 32'h4000_0000;
  localparam logic [31:0] SP_MASK    = 32'hFFC0_0000;
  localparam logic [31:0] PG_MASK    = 32'hFFFF_F000;
  localparam logic [31:0] KVER_REPLY = 32'h0000_0100;
  localparam logic [7:0]  SP_DESC    = 8'd88;
  localparam logic [31:0] PG_DESC    = 32'd48;
  localparam logic [31:0] SP_DESCW   = 32'd88;

  typedef enum logic [3:0] {
    OP_MARK, OP_KGRANT, OP_KVER, OP_FAIL, OP_UANY,
    OP_UINFO, OP_USUPER, OP_U4K, OP_DEVICE, OP_ECHO
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] page_index;
    logic [2:0]  mark_status;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_stat_t;

  typedef struct packed {
    logic                valid;
    logic [CFG_IW-1:0]   index;
    logic [FRAME_W-1:0]  value;
  } cfg_wr_t;

  typedef enum logic [3:0] {
    BS_CLEAR, BS_IDLE, BS_KCHK, BS_KEVAL, BS_UCHK, BS_UEVAL,
    BS_SRD, BS_SEVAL, BS_STAKE, BS_TRD, BS_TEVAL
  } back_state_t;

  function automatic logic in_table(logic [FRAME_XW-1:0] f, logic [FRAME_W-1:0] low);
    logic [FRAME_XW-1:0] d;
    d = f - {1'b0, low};
    return (f >= {1'b0, low}) && (d < FRAME_XW'(MAX_PAGES));
  endfunction

  function automatic logic [TBL_AW-1:0] slot_of(logic [FRAME_XW-1:0] f,
                                                 logic [FRAME_W-1:0] low);
    logic [FRAME_XW-1:0] d;
    d = f - {1'b0, low};
    return d[TBL_AW-1:0];
  endfunction

endpackage

// ===== hw/rtl/pfga_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pfga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== hw/rtl/pfga_front.sv =====
// Front end: takes items and classifies them into commands.
module pfga_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              operation,
  input  logic [15:0]       page_index,
  input  logic [2:0]        mark_status,
  input  logic              from_kernel,
  input  logic [31:0]       req_word0,
  input  logic [31:0]       req_word1,
  input  logic [31:0]       req_word2,
  input  logic              q_full,
  output pfga_pkg::cmd_push_t push,
  output logic              pending
);
  import pfga_pkg::*;

  logic fv;
  cmd_t slot;
  cmd_t cls;

  always_comb begin
    cls.page_index  = page_index;
    cls.mark_status = (mark_status > ST_ROOT) ? ST_RESERVED : mark_status;
    cls.w0 = req_word0;
    cls.w1 = req_word1;
    cls.w2 = req_word2;
    if (!operation) begin
      cls.op = OP_MARK;
    end else if (from_kernel) begin
      if (req_word0 == W_ANY || req_word0 == W_ANY_ALT) cls.op = OP_KGRANT;
      else if (req_word0 == W_INFO && req_word1[7:0] == 8'd0) cls.op = OP_KVER;
      else cls.op = OP_FAIL;
    end else if (req_word0 == W_ANY) begin
      cls.op = OP_UANY;
    end else if (req_word0 == W_INFO) begin
      cls.op = (req_word1[7:0] == 8'd1) ? OP_UINFO : OP_FAIL;
    end else if (req_word0 <= W_USER_TOP) begin
      cls.op = (req_word0[0] && req_word1[7:0] == SP_DESC) ? OP_USUPER : OP_U4K;
    end else if (req_word0 >= W_WIN_LO && req_word0 <= W_WIN_HI) begin
      cls.op = OP_DEVICE;
    end else begin
      cls.op = OP_ECHO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (fv && !q_full) begin
      fv <= 1'b0;
    end
    if (accept) begin
      slot <= cls;
    end
  end

  assign push.valid = fv && !q_full;
  assign push.cmd   = slot;
  assign pending    = fv;
endmodule

// ===== hw/rtl/pfga_queue.sv =====
// Two-entry command queue between front and back.
module pfga_queue (
  input  logic                clk,
  input  logic                rst,
  input  pfga_pkg::cmd_push_t push,
  input  logic                pop,
  output logic                full,
  output logic                valid,
  output pfga_pkg::cmd_t      head
);
  import pfga_pkg::*;

  cmd_t       ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push.valid) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push.valid) - 2'(pop);
    end
    if (push.valid) begin
      ent[wp] <= push.cmd;
    end
  end

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign head  = ent[rp];
endmodule

// ===== hw/rtl/pfga_back.sv =====
// Back end: status table, scan pointers and request execution.
module pfga_back (
  input  logic                  clk,
  input  logic                  rst,
  input  pfga_pkg::cfg_wr_t     cfg,
  input  logic                  q_valid,
  input  pfga_pkg::cmd_t        q_head,
  output logic                  pop,
  output pfga_pkg::back_stat_t  stat,
  output logic                  done,
  output logic [1:0]            reply_kind,
  output logic [31:0]           reply_word0,
  output logic [31:0]           reply_word1,
  output logic [31:0]           reply_word2
);
  import pfga_pkg::*;

  back_state_t state, state_next;
  cmd_t        cmd;
  logic [FRAME_W-1:0]  mem_low, mem_high, info_frame;
  logic [FRAME_W-1:0]  uscan, uscan_next, kscan, kscan_next;
  logic [FRAME_XW-1:0] cur, cur_next;
  logic [SP_CW-1:0]    cnt, cnt_next;
  logic [TBL_AW-1:0]   clr, clr_next;
  logic                intab, intab_next;

  logic                wr_en;
  logic [TBL_AW-1:0]   wr_addr, rd_addr;
  logic [2:0]          wr_data, rd_data;

  logic                rep_en;
  logic [1:0]          rep_kind;
  logic [31:0]         rep_w0, rep_w1, rep_w2;

  logic [FRAME_XW-1:0] tend, limit, sp_frame, kstart;
  logic [31:0]         addr4k, addrsp, addrdev;
  logic                is_free;

  pfga_ram #(.WIDTH(3), .DEPTH(MAX_PAGES)) u_table (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_comb begin
    tend     = {1'b0, mem_low} + FRAME_XW'(MAX_PAGES);
    limit    = ({1'b0, mem_high} < tend) ? {1'b0, mem_high} : tend;
    sp_frame = cur + FRAME_XW'(cnt);
    kstart   = {1'b0, kscan};
    if (kscan > mem_low && ({1'b0, kscan} - {1'b0, mem_low}) >= FRAME_XW'(MAX_PAGES)) begin
      kstart = tend - FRAME_XW'(1);
    end
    addr4k  = {cur[FRAME_W-1:0], 12'd0};
    addrsp  = cmd.w0 & SP_MASK;
    addrdev = (q_head.w0 & SP_MASK) + DEV_OFFSET;
    is_free = intab && rd_data == ST_FREE;
  end

  always_comb begin
    state_next = state;
    uscan_next = uscan;
    kscan_next = kscan;
    cur_next   = cur;
    cnt_next   = cnt;
    clr_next   = clr;
    intab_next = intab;
    pop        = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = slot_of(cur, mem_low);
    wr_data    = ST_GONE;
    rd_addr    = slot_of(cur, mem_low);
    rep_en     = 1'b0;
    rep_kind   = KIND_REG;
    rep_w0     = '0;
    rep_w1     = '0;
    rep_w2     = '0;
    case (state)
      BS_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr;
        wr_data  = ST_RESERVED;
        clr_next = clr + TBL_AW'(1);
        if (clr == TBL_AW'(MAX_PAGES - 1)) state_next = BS_IDLE;
      end
      BS_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_head.op)
            OP_MARK: begin
              wr_en   = {16'd0, q_head.page_index} < 32'(MAX_PAGES);
              wr_addr = TBL_AW'(q_head.page_index);
              wr_data = q_head.mark_status;
            end
            OP_KGRANT: begin
              cur_next   = kstart;
              state_next = BS_KCHK;
            end
            OP_UANY: begin
              cur_next   = {1'b0, uscan};
              state_next = BS_UCHK;
            end
            OP_USUPER: begin
              cur_next   = {1'b0, q_head.w0[31:22], 10'd0};
              cnt_next   = '0;
              state_next = BS_SRD;
            end
            OP_U4K: begin
              cur_next   = {1'b0, q_head.w0[31:12]};
              state_next = BS_TRD;
            end
            OP_KVER: begin
              rep_en = 1'b1;
              rep_w0 = KVER_REPLY;
              rep_w1 = q_head.w1;
              rep_w2 = q_head.w2;
            end
            OP_UINFO: begin
              rep_en   = 1'b1;
              rep_kind = KIND_MAP;
              rep_w1   = {info_frame, 12'd0} | PG_DESC;
            end
            OP_DEVICE: begin
              rep_en   = 1'b1;
              rep_kind = KIND_MAP;
              rep_w0   = addrdev;
              rep_w1   = addrdev | SP_DESCW | 32'd2;
            end
            OP_ECHO: begin
              rep_en   = 1'b1;
              rep_kind = KIND_MAP;
              rep_w0   = q_head.w0;
              rep_w1   = q_head.w1;
              rep_w2   = q_head.w2;
            end
            default: begin
              rep_en = 1'b1;
            end
          endcase
        end
      end
      BS_KCHK: begin
        if (cur <= {1'b0, mem_low}) begin
          kscan_next = cur[FRAME_W-1:0];
          rep_en     = 1'b1;
          state_next = BS_IDLE;
        end else begin
          intab_next = in_table(cur, mem_low);
          state_next = BS_KEVAL;
        end
      end
      BS_KEVAL: begin
        if (is_free) begin
          wr_en      = 1'b1;
          kscan_next = cur[FRAME_W-1:0];
          rep_en     = 1'b1;
          rep_kind   = KIND_MAP;
          rep_w0     = addr4k;
          rep_w1     = addr4k | PG_DESC | 32'd3;
          state_next = BS_IDLE;
        end else begin
          cur_next   = cur - FRAME_XW'(1);
          state_next = BS_KCHK;
        end
      end
      BS_UCHK: begin
        if (cur >= limit) begin
          uscan_next = cur[FRAME_W-1:0];
          rep_en     = 1'b1;
          state_next = BS_IDLE;
        end else begin
          intab_next = in_table(cur, mem_low);
          state_next = BS_UEVAL;
        end
      end
      BS_UEVAL: begin
        if (is_free) begin
          wr_en      = 1'b1;
          uscan_next = cur[FRAME_W-1:0];
          rep_en     = 1'b1;
          rep_kind   = KIND_MAP;
          rep_w0     = addr4k;
          rep_w1     = addr4k | PG_DESC | 32'd2;
          state_next = BS_IDLE;
        end else begin
          cur_next   = cur + FRAME_XW'(1);
          state_next = BS_UCHK;
        end
      end
      BS_SRD: begin
        rd_addr    = slot_of(sp_frame, mem_low);
        intab_next = in_table(sp_frame, mem_low);
        state_next = BS_SEVAL;
      end
      BS_SEVAL: begin
        if (!is_free) begin
          rep_en     = 1'b1;
          rep_w0     = cmd.w0;
          rep_w1     = cmd.w1;
          rep_w2     = cmd.w2;
          state_next = BS_IDLE;
        end else begin
          cnt_next   = cnt + SP_CW'(1);
          state_next = (cnt == SP_CW'(SP_FRAMES - 1)) ? BS_STAKE : BS_SRD;
        end
      end
      BS_STAKE: begin
        wr_en    = in_table(sp_frame, mem_low);
        wr_addr  = slot_of(sp_frame, mem_low);
        cnt_next = cnt + SP_CW'(1);
        if (cnt == SP_CW'(SP_FRAMES - 1)) begin
          rep_en     = 1'b1;
          rep_kind   = KIND_MAP;
          rep_w0     = addrsp;
          rep_w1     = addrsp | SP_DESCW | 32'd2;
          state_next = BS_IDLE;
        end
      end
      BS_TRD: begin
        intab_next = in_table(cur, mem_low);
        state_next = BS_TEVAL;
      end
      BS_TEVAL: begin
        rep_en     = 1'b1;
        state_next = BS_IDLE;
        if (intab && (rd_data == ST_FREE || rd_data == ST_SHARED)) begin
          wr_en    = rd_data == ST_FREE;
          rep_kind = KIND_MAP;
          rep_w0   = cmd.w0 & PG_MASK;
          rep_w1   = (cmd.w0 & PG_MASK) | PG_DESC | 32'd2;
        end
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BS_CLEAR;
      clr        <= '0;
      mem_low    <= '0;
      mem_high   <= MEM_HIGH_RST;
      info_frame <= '0;
      uscan      <= '0;
      kscan      <= MEM_HIGH_RST - FRAME_W'(1);
      done       <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      uscan <= uscan_next;
      kscan <= kscan_next;
      done  <= rep_en;
      if (cfg.valid) begin
        case (cfg.index)
          CFG_MEM_LOW: begin
            mem_low <= cfg.value;
            uscan   <= cfg.value;
          end
          CFG_MEM_HIGH: begin
            mem_high <= cfg.value;
            kscan    <= cfg.value - FRAME_W'(1);
          end
          CFG_INFO: info_frame <= cfg.value;
          default: ;
        endcase
      end
    end
    cur   <= cur_next;
    cnt   <= cnt_next;
    intab <= intab_next;
    if (pop) cmd <= q_head;
    if (rep_en) begin
      reply_kind  <= rep_kind;
      reply_word0 <= rep_w0;
      reply_word1 <= rep_w1;
      reply_word2 <= rep_w2;
    end
  end

  assign stat.clearing = state == BS_CLEAR;
  assign stat.idle     = state == BS_IDLE;
endmodule

// ===== hw/rtl/page_frame_grant_allocator_top.sv =====
// Top level of the page frame grant allocator.
// From the input transfer: a mark is written once the back end takes it from the queue;
// plain replies come straight from idle; a 4K request reads its frame, then replies; scans
// read one frame at a time until one is free or the bound is hit; a superpage reads its 1024
// frames, then takes them in a write pass, and stops early when a frame is not free. Throughput
// is set by the back end, which serves one command at a time; the queue hides the front. After
// reset the 65536 entries are cleared to reserved with busy high; the receiver cannot stall.
module page_frame_grant_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [15:0]                   page_index,
  input  logic [2:0]                    mark_status,
  input  logic                          from_kernel,
  input  logic [31:0]                   req_word0,
  input  logic [31:0]                   req_word1,
  input  logic [31:0]                   req_word2,
  output logic                          done,
  output logic [1:0]                    reply_kind,
  output logic [31:0]                   reply_word0,
  output logic [31:0]                   reply_word1,
  output logic [31:0]                   reply_word2,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfga_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data
);
  import pfga_pkg::*;

  cmd_push_t  push;
  cmd_t       q_head;
  back_stat_t back_stat;
  cfg_wr_t    cfg;
  logic       pending, q_full, q_valid, pop, accept;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.value = cfg_data[FRAME_W-1:0];

  assign busy   = pending || back_stat.clearing;
  assign accept = start && !busy;

  pfga_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .operation(operation),
    .page_index(page_index), .mark_status(mark_status), .from_kernel(from_kernel),
    .req_word0(req_word0), .req_word1(req_word1), .req_word2(req_word2),
    .q_full(q_full), .push(push), .pending(pending)
  );

  pfga_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .pop(pop),
    .full(q_full), .valid(q_valid), .head(q_head)
  );

  pfga_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_head(q_head),
    .pop(pop), .stat(back_stat), .done(done), .reply_kind(reply_kind),
    .reply_word0(reply_word0), .reply_word1(reply_word1), .reply_word2(reply_word2)
  );

`ifndef NO_ASSERTIONS
  a_clear_after_rst: assert property (@(posedge clk) rst |=> back_stat.clearing)
    else $error("table clear not started after reset");
  a_no_reply_clear: assert property (@(posedge clk) disable iff (rst)
    back_stat.clearing |-> !done && !pop)
    else $error("work done during table clear");
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid && back_stat.idle)
    else $error("queue popped outside idle or when empty");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !q_full)
    else $error("push into full queue");
`endif
endmodule

// ===== sim/tb.sv =====
// Testbench for the page frame grant allocator: directed table, then random phases.
`timescale 1ns / 100ps

module tb;
  import pfga_pkg::*;

  localparam bit OPER_MARK = 1'b0;
  localparam bit OPER_REQ  = 1'b1;
  localparam int WATCHDOG_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
  } reply_t;

  typedef struct packed {
    logic        oper;
    logic [15:0] idx;
    logic [2:0]  st;
    logic        kern;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic        typed;
    reply_t      want;
  } item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic operation = 1'b0;
  logic [15:0] page_index = '0;
  logic [2:0] mark_status = '0;
  logic from_kernel = 1'b0;
  logic [31:0] req_word0 = '0, req_word1 = '0, req_word2 = '0;
  logic done;
  logic [1:0] reply_kind;
  logic [31:0] reply_word0, reply_word1, reply_word2;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  page_frame_grant_allocator_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [2:0]  frame_tbl [MAX_PAGES];
  logic [31:0] lo_pg, hi_pg, info_pg, up_scan, down_scan;
  reply_t      pending_replies[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          gaps_on = 1'b1;

  function automatic logic [2:0] frame_rd(logic [31:0] f);
    if (f < lo_pg || f - lo_pg >= MAX_PAGES) return ST_RESERVED;
    return frame_tbl[f - lo_pg];
  endfunction

  function automatic void frame_take(logic [31:0] f);
    if (f < lo_pg || f - lo_pg >= MAX_PAGES) return;
    frame_tbl[f - lo_pg] = ST_GONE;
  endfunction

  function automatic reply_t rep(logic [1:0] k, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    reply_t r;
    r.kind = k; r.w0 = a; r.w1 = b; r.w2 = c;
    return r;
  endfunction

  function automatic reply_t grant_down();
    logic [31:0] k, a;
    k = down_scan;
    if (k > lo_pg && k - lo_pg >= MAX_PAGES) k = lo_pg + MAX_PAGES - 1;
    while (k > lo_pg && frame_rd(k) != ST_FREE) k--;
    down_scan = k & 32'hFFFFF;
    if (k <= lo_pg) return rep(KIND_REG, 0, 0, 0);
    frame_take(k);
    a = k << 12;
    return rep(KIND_MAP, a, a | PG_DESC | 32'd3, 0);
  endfunction

  function automatic reply_t grant_up();
    logic [31:0] lim, tend, u, a;
    lim = hi_pg;
    tend = lo_pg + MAX_PAGES;
    u = up_scan;
    if (lim > tend) lim = tend;
    while (u < lim && frame_rd(u) != ST_FREE) u++;
    up_scan = u & 32'hFFFFF;
    if (u >= lim) return rep(KIND_REG, 0, 0, 0);
    frame_take(u);
    a = u << 12;
    return rep(KIND_MAP, a, a | PG_DESC | 32'd2, 0);
  endfunction

  function automatic reply_t grant_named(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2);
    logic [31:0] adr, base, f, a;
    logic [2:0] s;
    if (w0[0] && w1[7:0] == SP_DESC) begin
      adr = w0 & SP_MASK;
      base = adr >> 12;
      for (int i = 0; i < SP_FRAMES; i++)
        if (frame_rd(base + i) != ST_FREE) return rep(KIND_REG, w0, w1, w2);
      for (int i = 0; i < SP_FRAMES; i++) frame_take(base + i);
      return rep(KIND_MAP, adr, adr | SP_DESCW | 32'd2, 0);
    end
    f = w0 >> 12;
    s = frame_rd(f);
    a = w0 & PG_MASK;
    if (s != ST_FREE && s != ST_SHARED) return rep(KIND_REG, 0, 0, 0);
    if (s == ST_FREE) frame_take(f);
    return rep(KIND_MAP, a, a | PG_DESC | 32'd2, 0);
  endfunction

  // updates state; returns 1 with the reply when the item gives one
  function automatic bit serve(item_t it, output reply_t r);
    logic [31:0] a;
    r = '0;
    if (it.oper == OPER_MARK) begin
      frame_tbl[it.idx] = (it.st > ST_ROOT) ? ST_RESERVED : it.st;
      return 1'b0;
    end
    if (it.kern) begin
      if (it.w0 == W_ANY || it.w0 == W_ANY_ALT) r = grant_down();
      else if (it.w0 == W_INFO && it.w1[7:0] == 8'h00) r = rep(KIND_REG, KVER_REPLY, it.w1, it.w2);
      else r = rep(KIND_REG, 0, 0, 0);
    end else if (it.w0 == W_ANY) begin
      r = grant_up();
    end else if (it.w0 == W_INFO) begin
      if (it.w1[7:0] == 8'h01) r = rep(KIND_MAP, 0, ({12'd0, info_pg[19:0]} << 12) | PG_DESC, 0);
      else r = rep(KIND_REG, 0, 0, 0);
    end else if (it.w0 <= W_USER_TOP) begin
      r = grant_named(it.w0, it.w1, it.w2);
    end else if (it.w0 >= W_WIN_LO && it.w0 <= W_WIN_HI) begin
      a = (it.w0 & SP_MASK) + DEV_OFFSET;
      r = rep(KIND_MAP, a, a | SP_DESCW | 32'd2, 0);
    end else begin
      r = rep(KIND_MAP, it.w0, it.w1, it.w2);
    end
    return 1'b1;
  endfunction

  function automatic item_t mark(logic [15:0] i, logic [2:0] s);
    item_t it;
    it = '0; it.oper = OPER_MARK; it.idx = i; it.st = s;
    it.w0 = $urandom(); it.w1 = $urandom(); it.w2 = $urandom();
    it.kern = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic item_t req(logic k, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    item_t it;
    it = '0; it.oper = OPER_REQ; it.kern = k; it.w0 = a; it.w1 = b; it.w2 = c;
    it.idx = 16'($urandom()); it.st = 3'($urandom());
    return it;
  endfunction

  function automatic item_t req_typed(logic k, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                      reply_t want);
    item_t it;
    it = req(k, a, b, c);
    it.typed = 1'b1; it.want = want;
    return it;
  endfunction

  task automatic send(item_t it);
    bit took;
    reply_t r;
    while (gaps_on && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= it.oper; page_index <= it.idx; mark_status <= it.st;
    from_kernel <= it.kern; req_word0 <= it.w0; req_word1 <= it.w1; req_word2 <= it.w2;
    do begin
      @(negedge clk) took = !busy;
      @(posedge clk);
    end while (!took);
    if (serve(it, r)) pending_replies.push_back(it.typed ? it.want : r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_bounds(logic [19:0] lo, logic [19:0] hi, logic [19:0] info);
    logic [19:0] vals [3];
    bit took;
    vals[0] = lo; vals[1] = hi; vals[2] = info;
    drain();
    for (int i = 0; i < 3; i++) begin
      while (gaps_on && $urandom_range(99) < 8) begin
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CFG_MEM_LOW : (i == 1) ? CFG_MEM_HIGH : CFG_INFO;
      cfg_data <= {12'($urandom()), vals[i]};
      do begin
        @(negedge clk) took = cfg_ready;
        @(posedge clk);
      end while (!took);
    end
    cfg_valid <= 1'b0;
    lo_pg = 32'(lo); up_scan = 32'(lo);
    hi_pg = 32'(hi); down_scan = (32'(hi) - 32'd1) & 32'hFFFFF;
    info_pg = 32'(info);
  endtask

  function automatic item_t rand_item(logic [31:0] lo, logic [31:0] hi);
    int span, c;
    logic [31:0] f, w0, w1, w2;
    span = (hi > lo) ? int'(hi - lo) : 1;
    if (span > 256) span = 256;
    w1 = $urandom(); w2 = $urandom();
    if ($urandom_range(99) < 30) begin
      f = ($urandom_range(99) < 85) ? $urandom_range(0, span + 8) : $urandom();
      return mark(f[15:0], ($urandom_range(1)) ? ST_FREE : 3'($urandom()));
    end
    c = $urandom_range(99);
    if ($urandom_range(99) < 35) begin
      if (c < 60) w0 = $urandom_range(1) ? W_ANY : W_ANY_ALT;
      else if (c < 75) begin
        w0 = W_INFO;
        if ($urandom_range(1)) w1[7:0] = 8'h00;
      end else w0 = $urandom();
      return req(1'b1, w0, w1, w2);
    end
    if (c < 25) w0 = W_ANY;
    else if (c < 35) begin
      w0 = W_INFO;
      if ($urandom_range(1)) w1[7:0] = 8'h01;
    end else if (c < 65) begin
      f = lo + $urandom_range(0, span + 4);
      w0 = {f[19:0], 12'($urandom())};
      if (w1[7:0] == SP_DESC) w1[7:0] = 8'h00;
    end else if (c < 68) begin
      w0 = ($urandom() & 32'h3FC0_0000) | 32'd1;
      w1[7:0] = SP_DESC;
    end else if (c < 80) w0 = $urandom_range(W_WIN_HI, W_WIN_LO);
    else if (c < 84) w0 = $urandom_range(32'h4000_0003, 32'h4000_0001);
    else if (c < 88) w0 = $urandom_range(32'hFFFF_FFFB, 32'hC000_0001);
    else if (c < 90) w0 = $urandom_range(1) ? 32'hFFFF_FFFD : 32'hFFFF_FFFF;
    else w0 = $urandom();
    return req(1'b0, w0, w1, w2);
  endfunction

  // result check
  always @(negedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply kind=%0d %h %h %h",
                                       reply_kind, reply_word0, reply_word1, reply_word2);
      end else begin
        want = pending_replies.pop_front();
        if (reply_kind !== want.kind || reply_word0 !== want.w0 ||
            reply_word1 !== want.w1 || reply_word2 !== want.w2) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply mismatch: exp %0d %h %h %h got %0d %h %h %h", want.kind,
                     want.w0, want.w1, want.w2, reply_kind, reply_word0, reply_word1,
                     reply_word2);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(negedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    item_t dir[$];
    logic [19:0] lo, hi;
    for (int i = 0; i < MAX_PAGES; i++) frame_tbl[i] = ST_RESERVED;
    lo_pg = 0; hi_pg = 32'(MEM_HIGH_RST); info_pg = 0; up_scan = 0; down_scan = 32'hFFFF;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, at reset bounds
    dir.push_back(mark(16'hFFFF, ST_FREE));
    dir.push_back(mark(16'hFFFE, ST_FREE));
    dir.push_back(mark(16'd5, ST_FREE));
    dir.push_back(mark(16'd6, ST_SHARED));
    dir.push_back(mark(16'd7, 3'd7));
    dir.push_back(mark(16'd8, ST_ROOT));
    dir.push_back(req(1'b1, W_ANY, $urandom(), $urandom()));
    dir.push_back(req(1'b1, W_ANY_ALT, $urandom(), $urandom()));
    dir.push_back(req_typed(1'b1, W_INFO, 32'hFFFF_FF00, 32'hFFFF_FFFF,
                            rep(KIND_REG, KVER_REPLY, 32'hFFFF_FF00, 32'hFFFF_FFFF)));
    dir.push_back(req_typed(1'b1, W_INFO, 32'h1, 32'h5, rep(KIND_REG, 0, 0, 0)));
    dir.push_back(req_typed(1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0, rep(KIND_REG, 0, 0, 0)));
    dir.push_back(req(1'b0, W_ANY, 32'h0, 32'h0));
    dir.push_back(req_typed(1'b0, W_INFO, 32'h101, 32'h7, rep(KIND_MAP, 0, PG_DESC, 0)));
    dir.push_back(req_typed(1'b0, W_INFO, 32'h2, 32'h7, rep(KIND_REG, 0, 0, 0)));
    dir.push_back(req(1'b0, 32'h0000_6ABC, 32'h0, 32'h0));
    dir.push_back(req_typed(1'b0, 32'h0000_7000, 32'h0, 32'h0, rep(KIND_REG, 0, 0, 0)));
    dir.push_back(req_typed(1'b0, 32'h1000_0000, 32'h0, 32'h0, rep(KIND_REG, 0, 0, 0)));
    dir.push_back(req_typed(1'b0, 32'h0, 32'h0, 32'h0, rep(KIND_REG, 0, 0, 0)));
    dir.push_back(req_typed(1'b0, 32'h0040_0001, 32'h58, 32'hABCD,
                            rep(KIND_REG, 32'h0040_0001, 32'h58, 32'hABCD)));
    dir.push_back(req_typed(1'b0, W_USER_TOP, 32'h0, 32'h0, rep(KIND_REG, 0, 0, 0)));
    dir.push_back(req(1'b0, W_WIN_LO, 32'h0, 32'h0));
    dir.push_back(req(1'b0, W_WIN_HI, 32'h0, 32'h0));
    dir.push_back(req_typed(1'b0, 32'h4000_0001, 32'h1, 32'h2,
                            rep(KIND_MAP, 32'h4000_0001, 32'h1, 32'h2)));
    dir.push_back(req_typed(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            rep(KIND_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF)));
    dir.push_back(req_typed(1'b0, 32'h0FFF_F000, 32'h0, 32'h0, rep(KIND_REG, 0, 0, 0)));
    foreach (dir[i]) send(dir[i]);

    // superpage: free the first 64 slots of the 4M frame so the check stops part way
    set_bounds(20'd0, 20'd2048, 20'hFFFFF);
    for (int i = 1024; i < 1088; i++) send(mark(16'(i), ST_FREE));
    send(req(1'b0, 32'h0040_0001, {24'($urandom()), SP_DESC}, $urandom()));
    send(req(1'b0, 32'h0040_0FFF, {24'($urandom()), SP_DESC}, $urandom()));
    repeat (40) send(rand_item(0, 2048));

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin lo = 20'h100; hi = 20'h180; end
        1: begin lo = 20'hFFFFF; hi = 20'h0; end
        2: begin lo = 20'hFFF00; hi = 20'hFFFFF; end
        3: begin lo = 20'h3FF00; hi = 20'h40100; end
        4: begin lo = 20'($urandom()); hi = 20'(lo + $urandom_range(1, 250)); end
        default: begin
          lo = 20'($urandom_range(20'hFFFFF, 20'h100));
          hi = 20'(lo - $urandom_range(1, 255));
        end
      endcase
      set_bounds(lo, hi, (p == 1) ? 20'h0 : 20'($urandom()));
      gaps_on = (p != 2);
      repeat (55) send(rand_item(lo_pg, hi_pg));
    end
    gaps_on = 1'b1;

    drain();
    if (mismatches == 0 && pending_replies.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
